/* src/positional_insert_delete_list_unit_macros.svh */
// Assertion macros for the positional insert/delete list unit.
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_MACROS_SVH

// Checked while out of reset.
`define PIDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define PIDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/pidl_pkg.sv */
// Shared types, codes and constants of the positional insert/delete list unit.
package pidl_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned VAL_W        = 16;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CNT_OUT_W    = 4;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_DUMP_FWD = 2'd2,
    OP_DUMP_REV = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;        // run insert/delete/empty dump on the accepted request
    logic dump_start;  // latch direction, clear step counter
    logic dump_emit;   // load next dumped entry
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register free this cycle
    logic count_zero;
    logic dump_final;  // current step is the last entry
  } sts_t;

endpackage

/* src/positional_insert_delete_list_unit.sv */
// Positional insert/delete list unit: top level joining controller and datapath.
// Insert, delete and empty dump: one request per cycle while the result register is free,
// result registered and valid in the next cycle. Dump of n entries: n results, one per cycle
// while the output is not stalled, stepped by the dump counter; no request is taken meanwhile.
// Reset (rst_ni low, asynchronous) empties the list and clears the result valid flag;
// the list cells and result fields themselves are not reset.
`include "positional_insert_delete_list_unit_macros.svh"

module positional_insert_delete_list_unit #(
  parameter int unsigned CAPACITY = pidl_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pidl_pkg::OP_W-1:0]       operation_i,
  input  logic [pidl_pkg::POS_W-1:0]      position_i,
  input  logic [pidl_pkg::VAL_W-1:0]      entry_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pidl_pkg::STAT_W-1:0]     status_o,
  output logic [pidl_pkg::VAL_W-1:0]      value_out_o,
  output logic [pidl_pkg::CNT_OUT_W-1:0]  position_out_o,
  output logic [pidl_pkg::CNT_OUT_W-1:0]  count_out_o,
  output logic                            last_o
);

  pidl_pkg::cmd_t cmd;
  pidl_pkg::sts_t sts;

  pidl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  pidl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .entry_value_i  (entry_value_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .value_out_o    (value_out_o),
    .position_out_o (position_out_o),
    .count_out_o    (count_out_o),
    .last_o         (last_o)
  );

  `PIDL_ASSERT(a_no_req_in_dump, cmd.dump_emit |-> !in_ready_o, "request taken during dump")
  `PIDL_ASSERT(a_dump_blocks, (in_valid_i && in_ready_o && operation_i[1] && !sts.count_zero) |=> !in_ready_o, "dump did not block input")
  `PIDL_ASSERT(a_nonlast_ok, (out_valid_o && !last_o) |-> (status_o == pidl_pkg::STAT_OK), "non-final result not ok")
  `PIDL_ASSERT_ALWAYS(a_cmd_excl, $onehot0({cmd.exec, cmd.dump_start, cmd.dump_emit}), "conflicting commands")

endmodule

/* src/pidl_ctrl.sv */
// Controller state machine: request acceptance and dump sequencing.
module pidl_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [pidl_pkg::OP_W-1:0]    operation_i,
  input  pidl_pkg::sts_t               sts_i,
  output logic                         in_ready_o,
  output pidl_pkg::cmd_t               cmd_o
);

  pidl_pkg::state_e state_q, state_d;
  logic             is_dump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    is_dump    = (operation_i == pidl_pkg::OP_DUMP_FWD) ||
                 (operation_i == pidl_pkg::OP_DUMP_REV);
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      pidl_pkg::S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (is_dump && !sts_i.count_zero) begin
            cmd_o.dump_start = 1'b1;
            state_d          = pidl_pkg::S_DUMP;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      pidl_pkg::S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.dump_emit = 1'b1;
          if (sts_i.dump_final) begin
            state_d = pidl_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = pidl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/pidl_dpath.sv */
// Datapath: list cells with parallel shift, entry count, dump step and result register.
module pidl_dpath #(
  parameter int unsigned CAPACITY = pidl_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pidl_pkg::cmd_t                  cmd_i,
  output pidl_pkg::sts_t                  sts_o,
  input  logic [pidl_pkg::OP_W-1:0]       operation_i,
  input  logic [pidl_pkg::POS_W-1:0]      position_i,
  input  logic [pidl_pkg::VAL_W-1:0]      entry_value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [pidl_pkg::STAT_W-1:0]     status_o,
  output logic [pidl_pkg::VAL_W-1:0]      value_out_o,
  output logic [pidl_pkg::CNT_OUT_W-1:0]  position_out_o,
  output logic [pidl_pkg::CNT_OUT_W-1:0]  count_out_o,
  output logic                            last_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMPW = (CW + 1 > pidl_pkg::POS_W + 1) ? CW + 1 : pidl_pkg::POS_W + 1;

  logic [pidl_pkg::VAL_W-1:0] cells_q [CAPACITY];
  logic [pidl_pkg::VAL_W-1:0] cells_d [CAPACITY];
  logic [CW-1:0]              count_q, count_d, count_m1;
  logic [IW-1:0]              step_q, step_d, dump_idx, rd_idx;
  logic                       rev_q, rev_d;
  logic                       cells_we;

  logic                       out_valid_q, out_valid_d;
  logic [pidl_pkg::STAT_W-1:0]    status_q, status_d;
  logic [pidl_pkg::VAL_W-1:0]     value_q, value_d;
  logic [pidl_pkg::CNT_OUT_W-1:0] posout_q, posout_d;
  logic [pidl_pkg::CNT_OUT_W-1:0] cntout_q, cntout_d;
  logic                           last_q, last_d;

  logic [CMPW-1:0] pos_ext, cnt_ext, pi;
  logic [pidl_pkg::VAL_W-1:0] rd_data;
  logic ins_full, ins_bad, del_empty, del_bad;

  always_comb begin
    pos_ext   = CMPW'(position_i);
    cnt_ext   = CMPW'(count_q);
    pi        = pos_ext - CMPW'(1);
    count_m1  = count_q - CW'(1);
    ins_full  = (count_q == CW'(CAPACITY));
    ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
    del_empty = (count_q == '0);
    del_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
    dump_idx  = rev_q ? IW'(count_m1 - CW'(step_q)) : step_q;
    rd_idx    = cmd_i.exec ? IW'(pi) : dump_idx;
    rd_data   = cells_q[rd_idx];
  end

  always_comb begin
    cells_d     = cells_q;
    cells_we    = 1'b0;
    count_d     = count_q;
    step_d      = step_q;
    rev_d       = rev_q;
    status_d    = status_q;
    value_d     = value_q;
    posout_d    = posout_q;
    cntout_d    = cntout_q;
    last_d      = last_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      value_d     = '0;
      posout_d    = '0;
      last_d      = 1'b1;
      cntout_d    = pidl_pkg::CNT_OUT_W'(count_q);
      case (operation_i)
        pidl_pkg::OP_INSERT: begin
          if (ins_full) begin
            status_d = pidl_pkg::STAT_FULL;
          end else if (ins_bad) begin
            status_d = pidl_pkg::STAT_BADPOS;
          end else begin
            status_d = pidl_pkg::STAT_OK;
            cells_we = 1'b1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (CMPW'(i) == pi) begin
                cells_d[i] = entry_value_i;
              end else if (i > 0 && CMPW'(i) > pi) begin
                cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
              end
            end
            count_d  = count_q + CW'(1);
            cntout_d = pidl_pkg::CNT_OUT_W'(count_q + CW'(1));
          end
        end
        pidl_pkg::OP_DELETE: begin
          if (del_empty) begin
            status_d = pidl_pkg::STAT_EMPTY;
          end else if (del_bad) begin
            status_d = pidl_pkg::STAT_BADPOS;
          end else begin
            status_d = pidl_pkg::STAT_OK;
            value_d  = rd_data;
            cells_we = 1'b1;
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (CMPW'(i) >= pi) begin
                cells_d[i] = cells_q[i + 1];
              end
            end
            count_d  = count_m1;
            cntout_d = pidl_pkg::CNT_OUT_W'(count_m1);
          end
        end
        default: begin
          // dump of an empty list
          status_d = pidl_pkg::STAT_EMPTY;
          cntout_d = '0;
        end
      endcase
    end

    if (cmd_i.dump_start) begin
      step_d = '0;
      rev_d  = (operation_i == pidl_pkg::OP_DUMP_REV);
    end

    if (cmd_i.dump_emit) begin
      out_valid_d = 1'b1;
      status_d    = pidl_pkg::STAT_OK;
      value_d     = rd_data;
      posout_d    = pidl_pkg::CNT_OUT_W'(CW'(dump_idx) + CW'(1));
      cntout_d    = pidl_pkg::CNT_OUT_W'(count_q);
      last_d      = sts_o.dump_final;
      step_d      = step_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cells_we) begin
      cells_q <= cells_d;
    end
    step_q   <= step_d;
    rev_q    <= rev_d;
    status_q <= status_d;
    value_q  <= value_d;
    posout_q <= posout_d;
    cntout_q <= cntout_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.dump_final = (CW'(step_q) == count_m1);

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign value_out_o    = value_q;
  assign position_out_o = posout_q;
  assign count_out_o    = cntout_q;
  assign last_o         = last_q;

endmodule

/* test/tb_positional_insert_delete_list_unit.sv */
// Self-checking testbench for the positional insert/delete list unit.
`timescale 1ns / 1ps

module tb_positional_insert_delete_list_unit;

  localparam int unsigned CAP         = pidl_pkg::CAPACITY_DEF;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef logic [pidl_pkg::POS_W-1:0] pos_t;
  typedef logic [pidl_pkg::VAL_W-1:0] val_t;

  typedef struct packed {
    logic [pidl_pkg::STAT_W-1:0]    status;
    logic [pidl_pkg::VAL_W-1:0]     value;
    logic [pidl_pkg::CNT_OUT_W-1:0] position;
    logic [pidl_pkg::CNT_OUT_W-1:0] count;
    logic                           last;
  } list_result_t;

  class list_shadow;
    logic [pidl_pkg::VAL_W-1:0] shadow_cells [CAP];
    int unsigned                shadow_count;
    list_result_t               results_due [$];
    int unsigned                mismatch_count;

    function new();
      shadow_count   = 0;
      mismatch_count = 0;
    endfunction

    function void push_result(pidl_pkg::status_e st, logic [pidl_pkg::VAL_W-1:0] v,
                              int unsigned p, logic l);
      list_result_t r;
      r.status   = st;
      r.value    = v;
      r.position = p[pidl_pkg::CNT_OUT_W-1:0];
      r.count    = shadow_count[pidl_pkg::CNT_OUT_W-1:0];
      r.last     = l;
      results_due.push_back(r);
    endfunction

    function void note_request(pidl_pkg::op_e op, logic [pidl_pkg::POS_W-1:0] pos,
                               logic [pidl_pkg::VAL_W-1:0] val);
      int unsigned                idx;
      logic [pidl_pkg::VAL_W-1:0] removed;
      case (op)
        pidl_pkg::OP_INSERT: begin
          if (shadow_count >= CAP) begin
            push_result(pidl_pkg::STAT_FULL, '0, 0, 1'b1);
          end else if (pos < 1 || pos > shadow_count + 1) begin
            push_result(pidl_pkg::STAT_BADPOS, '0, 0, 1'b1);
          end else begin
            for (idx = shadow_count; idx > pos - 1; idx--)
              shadow_cells[idx] = shadow_cells[idx-1];
            shadow_cells[pos-1] = val;
            shadow_count++;
            push_result(pidl_pkg::STAT_OK, '0, 0, 1'b1);
          end
        end
        pidl_pkg::OP_DELETE: begin
          if (shadow_count == 0) begin
            push_result(pidl_pkg::STAT_EMPTY, '0, 0, 1'b1);
          end else if (pos < 1 || pos > shadow_count) begin
            push_result(pidl_pkg::STAT_BADPOS, '0, 0, 1'b1);
          end else begin
            removed = shadow_cells[pos-1];
            for (idx = pos - 1; idx + 1 < shadow_count; idx++)
              shadow_cells[idx] = shadow_cells[idx+1];
            shadow_count--;
            push_result(pidl_pkg::STAT_OK, removed, 0, 1'b1);
          end
        end
        default: begin
          if (shadow_count == 0) begin
            push_result(pidl_pkg::STAT_EMPTY, '0, 0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < shadow_count; i++) begin
              idx = (op == pidl_pkg::OP_DUMP_FWD) ? i : shadow_count - 1 - i;
              push_result(pidl_pkg::STAT_OK, shadow_cells[idx], idx + 1,
                          i + 1 == shadow_count);
            end
          end
        end
      endcase
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: st=%0d val=%h pos=%0d cnt=%0d last=%0b",
                   got.status, got.value, got.position, got.count, got.last);
        return;
      end
      want = results_due.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"mismatch: exp st=%0d val=%h pos=%0d cnt=%0d last=%0b, ",
                    "got st=%0d val=%h pos=%0d cnt=%0d last=%0b"},
                   want.status, want.value, want.position, want.count, want.last,
                   got.status, got.value, got.position, got.count, got.last);
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni         = 1'b0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_ready_o;
  logic [pidl_pkg::OP_W-1:0]      operation_i    = '0;
  logic [pidl_pkg::POS_W-1:0]     position_i     = '0;
  logic [pidl_pkg::VAL_W-1:0]     entry_value_i  = '0;
  logic                           out_valid_o;
  logic                           out_ready_i    = 1'b0;
  logic [pidl_pkg::STAT_W-1:0]    status_o;
  logic [pidl_pkg::VAL_W-1:0]     value_out_o;
  logic [pidl_pkg::CNT_OUT_W-1:0] position_out_o;
  logic [pidl_pkg::CNT_OUT_W-1:0] count_out_o;
  logic                           last_o;

  list_shadow  list_model   = new();
  int          stim_phase   = 0;
  int          send_idle_pct = 15;
  int          recv_idle_pct = 66;
  int unsigned issued_count = 0;
  int unsigned quiet_cycles = 0;

  positional_insert_delete_list_unit #(.CAPACITY(CAP)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .entry_value_i  (entry_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .value_out_o    (value_out_o),
    .position_out_o (position_out_o),
    .count_out_o    (count_out_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // requests are predicted before results of the same edge are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        list_model.note_request(pidl_pkg::op_e'(operation_i), position_i, entry_value_i);
      if (out_valid_o && out_ready_i)
        list_model.check_result({status_o, value_out_o, position_out_o, count_out_o,
                                 last_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (stim_phase == 2 && !hold_done) begin
        hold_done = 1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(pidl_pkg::op_e op, logic [pidl_pkg::POS_W-1:0] pos,
                              logic [pidl_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    position_i    <= pos;
    entry_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    case (op)
      pidl_pkg::OP_INSERT:
        if (issued_count < CAP && pos >= 1 && pos <= issued_count + 1) issued_count++;
      pidl_pkg::OP_DELETE:
        if (issued_count > 0 && pos >= 1 && pos <= issued_count) issued_count--;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    pidl_pkg::op_e op;
    pos_t          pos;
    val_t          val;
    int            r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list cases, bad positions, full list, every op
    send_request(pidl_pkg::OP_DUMP_FWD, 8'd1, 16'h0000);
    send_request(pidl_pkg::OP_DUMP_REV, 8'd1, 16'hFFFF);
    send_request(pidl_pkg::OP_DELETE, 8'd1, 16'h0000);
    send_request(pidl_pkg::OP_INSERT, 8'd0, 16'h1111);
    send_request(pidl_pkg::OP_INSERT, 8'd2, 16'h2222);
    send_request(pidl_pkg::OP_INSERT, 8'd255, 16'h3333);
    send_request(pidl_pkg::OP_INSERT, 8'd1, 16'hFFFF);
    send_request(pidl_pkg::OP_INSERT, 8'd1, 16'h0000);
    send_request(pidl_pkg::OP_INSERT, 8'd3, 16'h4142);
    send_request(pidl_pkg::OP_INSERT, 8'd2, 16'hA5A5);
    send_request(pidl_pkg::OP_INSERT, 8'd5, 16'h5A5A);
    send_request(pidl_pkg::OP_INSERT, 8'd6, 16'h1234);
    send_request(pidl_pkg::OP_INSERT, 8'd7, 16'hFEDC);
    send_request(pidl_pkg::OP_INSERT, 8'd8, 16'h8001);
    send_request(pidl_pkg::OP_INSERT, 8'd1, 16'h7777);
    send_request(pidl_pkg::OP_INSERT, 8'd0, 16'h6666);
    send_request(pidl_pkg::OP_DUMP_FWD, 8'd0, 16'h0000);
    send_request(pidl_pkg::OP_DUMP_REV, 8'd255, 16'hFFFF);
    send_request(pidl_pkg::OP_DELETE, 8'd0, 16'h0000);
    send_request(pidl_pkg::OP_DELETE, 8'd9, 16'h0000);
    send_request(pidl_pkg::OP_DELETE, 8'd255, 16'h0000);
    send_request(pidl_pkg::OP_DELETE, 8'd8, 16'h0000);
    send_request(pidl_pkg::OP_DELETE, 8'd1, 16'h0000);
    send_request(pidl_pkg::OP_DELETE, 8'd3, 16'h0000);
    send_request(pidl_pkg::OP_DUMP_FWD, 8'd0, 16'h0000);

    for (int ph = 0; ph < 3; ph++) begin
      stim_phase    = ph;
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 15 : 0;
      repeat (140) begin
        r = $urandom_range(99);
        if (r < 45)      op = pidl_pkg::OP_INSERT;
        else if (r < 80) op = pidl_pkg::OP_DELETE;
        else if (r < 90) op = pidl_pkg::OP_DUMP_FWD;
        else             op = pidl_pkg::OP_DUMP_REV;
        if (op == pidl_pkg::OP_INSERT && issued_count == CAP && $urandom_range(99) < 70)
          op = pidl_pkg::OP_DELETE;
        pos = pos_t'($urandom_range(255, 0));
        if ($urandom_range(99) < 85) begin
          if (op == pidl_pkg::OP_INSERT)
            pos = (issued_count < CAP) ? pos_t'($urandom_range(issued_count + 1, 1)) : pos;
          else if (op == pidl_pkg::OP_DELETE && issued_count > 0)
            pos = pos_t'($urandom_range(issued_count, 1));
        end
        val = val_t'($urandom);
        send_request(op, pos, val);
      end
    end
    in_valid_i <= 1'b0;

    while (list_model.results_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (list_model.mismatch_count == 0 && list_model.results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
